// ===== rtl/core/cxs_pkg.sv =====
`default_nettype none
package cxs_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned PAYLD_W  = 64;
  localparam int unsigned LEN_W    = 4;
  localparam int unsigned POS_W    = 3;
  localparam int unsigned FNUM_W   = 6;
  localparam int unsigned FLAG_W   = 2;
  localparam int unsigned ID_W     = 29;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PRIORITY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MCAST    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEST     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FUNC     = 3'd4;

  // Position flag codes: bit 1 marks the last frame, bit 0 the first.
  localparam logic [FLAG_W-1:0] FLAG_MIDDLE = 2'd0;
  localparam logic [FLAG_W-1:0] FLAG_FIRST  = 2'd1;
  localparam logic [FLAG_W-1:0] FLAG_LAST   = 2'd2;
  localparam logic [FLAG_W-1:0] FLAG_SINGLE = 2'd3;

  typedef struct packed {
    logic [1:0] priority_level;
    logic [5:0] source_node;
    logic [1:0] multicast_mode;
    logic [5:0] destination_node;
    logic [4:0] function_code;
  } cfg_t;

  // One packed frame waiting for its identifier.
  typedef struct packed {
    logic [FLAG_W-1:0]  flag;
    logic [FNUM_W-1:0]  frame_number;
    logic [LEN_W-1:0]   data_length;
    logic [PAYLD_W-1:0] payload;
  } frame_t;

  // Handshake between the queue and its neighbors.
  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage
`default_nettype wire

// ===== rtl/core/cxs_in_if.sv =====
`default_nettype none
interface cxs_in_if;
  logic                      valid;
  logic                      ready;
  logic [cxs_pkg::BYTE_W-1:0] data_byte;
  logic                      last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/cxs_out_if.sv =====
`default_nettype none
interface cxs_out_if;
  logic                        valid;
  logic                        ready;
  logic [cxs_pkg::ID_W-1:0]    can_id;
  logic [cxs_pkg::LEN_W-1:0]   data_length;
  logic [cxs_pkg::PAYLD_W-1:0] payload;

  modport source (output valid, output can_id, output data_length, output payload,
                  input ready);
  modport sink   (input valid, input can_id, input data_length, input payload,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/core/cxs_cfg_if.sv =====
`default_nettype none
interface cxs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cxs_pkg::CFG_IDX_W-1:0]  index;
  logic [cxs_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/cxs_packer.sv =====
`default_nettype none
module cxs_packer (
  input  wire logic            clk,
  input  wire logic            rst_n,
  cxs_in_if.sink               in_ch,
  input  wire logic            q_ready,
  output cxs_pkg::frame_t      q_frame,
  output logic                 q_valid
);

  logic [cxs_pkg::PAYLD_W-1:0] buf_r, buf_nxt;
  logic [cxs_pkg::POS_W-1:0]   held_r, held_nxt;
  logic [cxs_pkg::FNUM_W-1:0]  fnum_r, fnum_nxt;
  logic                        start_r, start_nxt;
  logic [cxs_pkg::PAYLD_W-1:0] merged;
  logic                        accept;
  logic                        frame_done;

  assign in_ch.ready = q_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign frame_done  = in_ch.last_byte || (held_r == {cxs_pkg::POS_W{1'b1}});
  assign merged      = buf_r | ({{(cxs_pkg::PAYLD_W-cxs_pkg::BYTE_W){1'b0}}, in_ch.data_byte}
                                << {held_r, 3'b000});

  assign q_valid              = accept && frame_done;
  assign q_frame.flag         = {in_ch.last_byte, start_r};
  assign q_frame.frame_number = fnum_r;
  assign q_frame.data_length  = {1'b0, held_r} + 4'd1;
  assign q_frame.payload      = merged;

  always_comb begin
    buf_nxt   = buf_r;
    held_nxt  = held_r;
    fnum_nxt  = fnum_r;
    start_nxt = start_r;
    if (accept) begin
      if (!frame_done) begin
        buf_nxt  = merged;
        held_nxt = held_r + 3'd1;
      end else begin
        buf_nxt  = '0;
        held_nxt = '0;
        if (in_ch.last_byte) begin
          fnum_nxt  = '0;
          start_nxt = 1'b1;
        end else begin
          fnum_nxt  = fnum_r + 6'd1;
          start_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r   <= '0;
      held_r  <= '0;
      fnum_r  <= '0;
      start_r <= 1'b1;
    end else begin
      buf_r   <= buf_nxt;
      held_r  <= held_nxt;
      fnum_r  <= fnum_nxt;
      start_r <= start_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/cxs_queue.sv =====
`default_nettype none
module cxs_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire cxs_pkg::frame_t  push_frame,
  output logic                  push_ready,
  input  wire logic             pop,
  output cxs_pkg::frame_t       pop_frame,
  output cxs_pkg::hs_t          status
);

  cxs_pkg::frame_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign push_ready   = (count_r != 2'd2);
  assign status.valid = (count_r != 2'd0);
  assign status.ready = push_ready;
  assign pop_frame    = mem_r[rd_ptr_r];
  assign do_push      = push && push_ready;
  assign do_pop       = pop && status.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/cxs_framer.sv =====
`default_nettype none
module cxs_framer (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cxs_pkg::cfg_t    cfg,
  input  wire cxs_pkg::hs_t     q_status,
  input  wire cxs_pkg::frame_t  q_frame,
  output logic                  q_pop,
  cxs_out_if.source             out_ch
);

  logic                        valid_r, valid_nxt;
  logic [cxs_pkg::ID_W-1:0]    id_r;
  logic [cxs_pkg::LEN_W-1:0]   len_r;
  logic [cxs_pkg::PAYLD_W-1:0] payload_r;
  logic                        slot_free;

  // The output register takes a new frame when empty or when its frame leaves.
  assign slot_free = !valid_r || out_ch.ready;
  assign q_pop     = q_status.valid && slot_free;

  always_comb begin
    valid_nxt = valid_r;
    if (slot_free) begin
      valid_nxt = q_status.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      id_r      <= {cfg.priority_level, cfg.source_node, cfg.multicast_mode,
                    cfg.destination_node, q_frame.flag, q_frame.frame_number,
                    cfg.function_code};
      len_r     <= q_frame.data_length;
      payload_r <= q_frame.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.can_id      = id_r;
  assign out_ch.data_length = len_r;
  assign out_ch.payload     = payload_r;

endmodule
`default_nettype wire

// ===== rtl/core/can_extended_id_segmenter_core.sv =====
`default_nettype none
// CAN extended-identifier segmenter.
// in_ch carries one message byte per transaction with last_byte set on the
// final byte. The bytes are packed, first byte lowest, into CAN data frames of
// up to eight bytes; a frame goes out on out_ch when its eighth byte arrives or
// the message ends, with unused payload bytes zero.
// can_id holds priority, source, multicast, destination, a position flag
// (3 single, 1 first, 2 last, 0 middle), a 6-bit wrapping frame number and the
// function code. cfg_ch writes the five header registers by index (0 priority,
// 1 source, 2 multicast, 3 destination, 4 function); writes are always taken,
// indexes above 4 are dropped, and writes belong to idle periods.
// Throughput: one byte per cycle while the frame queue has room. After the
// transaction of its closing byte, a frame passes through the two-entry frame
// queue and then the output register before it appears on out_ch.
// When out_ch stalls, the output register holds its frame, the queue absorbs
// up to two more frames, and in_ch.ready drops only while the queue is full.
// Reset (rst_n low, synchronous) empties the queue and output register, clears
// the partial frame and frame number, and loads the register reset values
// (priority 2, source 1, multicast 0, destination 10, function 0).
module can_extended_id_segmenter_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cxs_in_if.sink     in_ch,
  cxs_out_if.source  out_ch,
  cxs_cfg_if.sink    cfg_ch
);

  cxs_pkg::cfg_t   cfg_r, cfg_nxt;
  cxs_pkg::frame_t push_frame;
  cxs_pkg::frame_t pop_frame;
  cxs_pkg::hs_t    q_status;
  logic            push;
  logic            push_ready;
  logic            pop;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        cxs_pkg::REG_PRIORITY: cfg_nxt.priority_level   = cfg_ch.data[1:0];
        cxs_pkg::REG_SOURCE:   cfg_nxt.source_node      = cfg_ch.data[5:0];
        cxs_pkg::REG_MCAST:    cfg_nxt.multicast_mode   = cfg_ch.data[1:0];
        cxs_pkg::REG_DEST:     cfg_nxt.destination_node = cfg_ch.data[5:0];
        cxs_pkg::REG_FUNC:     cfg_nxt.function_code    = cfg_ch.data[4:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.priority_level   <= 2'd2;
      cfg_r.source_node      <= 6'd1;
      cfg_r.multicast_mode   <= 2'd0;
      cfg_r.destination_node <= 6'd10;
      cfg_r.function_code    <= 5'd0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cxs_packer u_packer (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_ready (push_ready),
    .q_frame (push_frame),
    .q_valid (push)
  );

  cxs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_frame (push_frame),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_frame  (pop_frame),
    .status     (q_status)
  );

  cxs_framer u_framer (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_status (q_status),
    .q_frame  (pop_frame),
    .q_pop    (pop),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire
